// ===== sv/rrwa_pkg.sv =====
// Shared constants, codes and control types for the round-robin worker allocator.
`timescale 1ns / 1ps
`default_nettype none

package rrwa_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int WIDX_W      = $clog2(MAX_WORKERS);
    localparam int CNT_W       = WIDX_W + 1;
    localparam int STATE_W     = 3;
    localparam int MODE_W      = 3;
    localparam int ERR_W       = 8;
    localparam int POOL_W      = 15;
    localparam int ID_W        = 31;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 56;

    // Worker state codes.
    localparam logic [STATE_W-1:0] ST_UNSTARTED  = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE       = 3'd1;
    localparam logic [STATE_W-1:0] ST_LOCKED     = 3'd2;
    localparam logic [STATE_W-1:0] ST_PROCESSING = 3'd3;
    localparam logic [STATE_W-1:0] ST_SHUTDOWN   = 3'd4;
    localparam logic [STATE_W-1:0] ST_ERROR      = 3'd5;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_START    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_JOB_BEG  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_JOB_END  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_WORKER = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

    // Configuration register indexes.
    localparam logic REG_ACTIVE_WORKERS = 1'b0;
    localparam logic REG_POOL_ID        = 1'b1;

    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // evaluate the item, update state and load the result
    } rrwa_cmd_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_idle_worker_allocator.sv =====
// Top level of the round-robin idle worker allocator.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Direction  Payload
//  s_       in         tuser: mode; tdata: worker_index, error_code
//  m_       out        tdata: granted, chosen_index, worker_id, worker_state,
//                      status, reported_error
//  cfg_     in         index 0 active_workers, index 1 pool_id
//
// Each item is first captured and then executed: in execution the rotated
// priority search over the idle bits and the state table update complete.
// Reset clears all workers to not started, the pointer to zero, the active
// count to the full pool and the pool id to zero. A result waiting in the
// output register does not block capture of the next item, but that item is
// not executed until the result is taken.

module round_robin_idle_worker_allocator import rrwa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [3:0] worker_index, [11:4] error_code, [15:12] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  wire logic [MODE_W-1:0]     s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] granted, [4:1] chosen_index, [35:5] worker_id, [38:36] worker_state,
    // [40:39] status, [48:41] reported_error, [55:49] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    rrwa_cmd_t cmd;

    rrwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rrwa_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_mode   (s_tuser),
        .in_index  (s_tdata[WIDX_W-1:0]),
        .in_error  (s_tdata[WIDX_W+ERR_W-1:WIDX_W]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/rrwa_ctrl.sv =====
// Controller state machine: input capture, execution and result handshake.
`timescale 1ns / 1ps
`default_nettype none

module rrwa_ctrl import rrwa_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output rrwa_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be free or emptying this cycle.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== sv/rrwa_dp.sv =====
// Datapath: worker state table, round-robin search, configuration and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrwa_dp import rrwa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rrwa_cmd_t             cmd,
    input  wire logic [MODE_W-1:0]     in_mode,
    input  wire logic [WIDX_W-1:0]     in_index,
    input  wire logic [ERR_W-1:0]      in_error,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [OUT_DATA_W-1:0]      out_data
);

    logic [STATE_W-1:0] states_reg [MAX_WORKERS];
    logic [WIDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]   active_reg;
    logic [POOL_W-1:0]  pool_reg;

    logic [MODE_W-1:0]  mode_reg;
    logic [WIDX_W-1:0]  index_reg;
    logic [ERR_W-1:0]   error_reg;

    logic                out_granted_next, out_granted_reg;
    logic [WIDX_W-1:0]   out_chosen_next, out_chosen_reg;
    logic [ID_W-1:0]     out_id_next, out_id_reg;
    logic [STATE_W-1:0]  out_state_next, out_state_reg;
    logic [STATUS_W-1:0] out_status_next, out_status_reg;
    logic [ERR_W-1:0]    out_err_next, out_err_reg;

    logic                wr_en;
    logic [WIDX_W-1:0]   wr_addr;
    logic [STATE_W-1:0]  wr_state;
    logic                ptr_we;

    logic [CNT_W-1:0]       n_eff;
    logic [WIDX_W-1:0]      start;
    logic [MAX_WORKERS-1:0] idle_mask;
    logic [MAX_WORKERS-1:0] upper_mask;
    logic [WIDX_W-1:0]      hit_hi, hit_lo, cur;
    logic [CNT_W-1:0]       cur_inc;
    logic                   index_ok;

    function automatic logic [WIDX_W-1:0] first_set(input logic [MAX_WORKERS-1:0] m);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
            if (m[i]) r = WIDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [ID_W-1:0] make_id(input logic [POOL_W-1:0] pool,
                                                input logic [WIDX_W-1:0] idx);
        return {pool, (ID_W - POOL_W - WIDX_W)'(0), idx};
    endfunction

    // A zero count acts as one worker, anything above the pool size as the full pool.
    always_comb begin
        if (active_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (active_reg > CNT_W'(MAX_WORKERS)) begin
            n_eff = CNT_W'(MAX_WORKERS);
        end else begin
            n_eff = active_reg;
        end
    end

    // The search starts at worker zero when the pointer lies past a shrunken pool.
    assign start = ({1'b0, ptr_reg} >= n_eff) ? '0 : ptr_reg;

    always_comb begin
        for (int i = 0; i < MAX_WORKERS; i++) begin
            idle_mask[i]  = (states_reg[i] == ST_IDLE) && (CNT_W'(i) < n_eff);
            upper_mask[i] = idle_mask[i] && (WIDX_W'(i) >= start);
        end
    end

    assign hit_hi   = first_set(upper_mask);
    assign hit_lo   = first_set(idle_mask);
    assign cur      = (|upper_mask) ? hit_hi : hit_lo;
    assign cur_inc  = {1'b0, cur} + CNT_W'(1);
    assign index_ok = {1'b0, index_reg} < n_eff;

    always_comb begin
        out_granted_next = 1'b0;
        out_chosen_next  = '0;
        out_id_next      = '0;
        out_state_next   = ST_UNSTARTED;
        out_status_next  = STAT_OK;
        out_err_next     = '0;
        wr_en            = 1'b0;
        wr_addr          = index_reg;
        wr_state         = ST_IDLE;
        ptr_we           = 1'b0;
        ptr_next         = ptr_reg;

        if (mode_reg == MODE_ACQUIRE) begin
            ptr_we = 1'b1;
            if (|idle_mask) begin
                wr_en            = 1'b1;
                wr_addr          = cur;
                wr_state         = ST_LOCKED;
                ptr_next         = (cur_inc == n_eff) ? '0 : cur_inc[WIDX_W-1:0];
                out_granted_next = 1'b1;
                out_chosen_next  = cur;
                out_id_next      = make_id(pool_reg, cur);
                out_state_next   = ST_LOCKED;
            end else begin
                // A full pass leaves the pointer where the search began.
                ptr_next        = start;
                out_status_next = STAT_NO_WORKER;
            end
        end else if (mode_reg inside {[MODE_START:MODE_ERROR], MODE_QUERY}) begin
            out_chosen_next = index_reg;
            out_id_next     = make_id(pool_reg, index_reg);
            if (!index_ok) begin
                out_status_next = STAT_BAD_INDEX;
            end else begin
                case (mode_reg)
                    MODE_START:    wr_state = ST_IDLE;
                    MODE_JOB_BEG:  wr_state = ST_PROCESSING;
                    MODE_JOB_END:  wr_state = ST_IDLE;
                    MODE_SHUTDOWN: wr_state = ST_SHUTDOWN;
                    MODE_ERROR:    wr_state = ST_ERROR;
                    default:       wr_state = ST_IDLE;
                endcase
                if (mode_reg == MODE_QUERY) begin
                    out_state_next = states_reg[index_reg];
                end else begin
                    wr_en          = 1'b1;
                    out_state_next = wr_state;
                end
                if (mode_reg == MODE_ERROR) begin
                    out_err_next = error_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WORKERS; i++) begin
                states_reg[i] <= ST_UNSTARTED;
            end
            ptr_reg    <= '0;
            active_reg <= CNT_W'(MAX_WORKERS);
            pool_reg   <= '0;
        end else begin
            if (cmd.exec && wr_en) begin
                states_reg[wr_addr] <= wr_state;
            end
            if (cmd.exec && ptr_we) begin
                ptr_reg <= ptr_next;
            end
            if (cfg_we) begin
                if (cfg_index == REG_ACTIVE_WORKERS) begin
                    active_reg <= cfg_wdata[CNT_W-1:0];
                end else begin
                    pool_reg <= cfg_wdata[POOL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            index_reg <= in_index;
            error_reg <= in_error;
        end
        if (cmd.exec) begin
            out_granted_reg <= out_granted_next;
            out_chosen_reg  <= out_chosen_next;
            out_id_reg      <= out_id_next;
            out_state_reg   <= out_state_next;
            out_status_reg  <= out_status_next;
            out_err_reg     <= out_err_next;
        end
    end

    assign out_data = {7'd0, out_err_reg, out_status_reg, out_state_reg,
                       out_id_reg, out_chosen_reg, out_granted_reg};

endmodule

`default_nettype wire
